@@ sv/ctb_pkg.sv @@
`timescale 1ns / 1ps

package ctb_pkg;

	localparam int BANK_SIZE_DEF  = 16;
	localparam int COUNT_BITS_DEF = 16;

	localparam logic [2:0] KIND_TICK  = 3'd0;
	localparam logic [2:0] KIND_LOAD  = 3'd1;
	localparam logic [2:0] KIND_START = 3'd2;
	localparam logic [2:0] KIND_STOP  = 3'd3;
	localparam logic [2:0] KIND_SET   = 3'd4;
	localparam logic [2:0] KIND_CLEAR = 3'd5;
	localparam logic [2:0] KIND_QUERY = 3'd6;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  timer_index;
		logic [15:0] load_value;
	} cmd_t;

	typedef struct packed {
		logic        status;
		logic        is_active;
		logic        is_expired;
		logic [31:0] now_time;
	} rsp_t;

endpackage

@@ sv/ctb_ram.sv @@
`timescale 1ns / 1ps

module ctb_ram #(
	parameter int WIDTH = ctb_pkg::COUNT_BITS_DEF,
	parameter int DEPTH = ctb_pkg::BANK_SIZE_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ sv/countdown_timer_bank_unit.sv @@
`timescale 1ns / 1ps

// Channel  Direction  Handshake            Payload
// cmd      in         cmd_valid/cmd_stall  ctb_pkg::cmd_t
// rsp      out        rsp_valid/rsp_stall  ctb_pkg::rsp_t
//
// Every timer operation other than a tick is applied as it is taken, and its result is registered.
// A tick sweeps the count memory one timer per cycle through the single
// memory read port, and cmd stalls until the sweep and its drain state end.
// Reset clears the masks, the tick counter and the per-entry valid bits.
// A stalled response sits in the output register while one more beat is
// taken; a second result then waits in a hold register and cmd stalls.

module countdown_timer_bank_unit #(
	parameter int BANK_SIZE  = ctb_pkg::BANK_SIZE_DEF,
	parameter int COUNT_BITS = ctb_pkg::COUNT_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  ctb_pkg::cmd_t cmd,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output ctb_pkg::rsp_t rsp
);

	localparam int IDX_W = (BANK_SIZE > 1) ? $clog2(BANK_SIZE) : 1;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SWEEP = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	logic [1:0]            state_q;
	logic [IDX_W-1:0]      sweep_q;
	logic [BANK_SIZE-1:0]  active_q;
	logic [BANK_SIZE-1:0]  expired_q;
	logic [BANK_SIZE-1:0]  valid_q;
	logic [31:0]           tick_q;

	logic                  wb_valid_s1;
	logic [IDX_W-1:0]      wb_idx_s1;

	logic                  rsp_valid_q;
	ctb_pkg::rsp_t         rsp_q;
	logic                  hold_valid_q;
	ctb_pkg::rsp_t         hold_q;

	logic                  cmd_fire;
	logic                  is_tick;
	logic                  in_range;
	logic [IDX_W-1:0]      idx;
	logic [BANK_SIZE-1:0]  sel_bit;
	logic [BANK_SIZE-1:0]  op_active;
	logic [BANK_SIZE-1:0]  op_expired;
	logic                  op_write;
	logic                  op_fire;

	logic [COUNT_BITS-1:0] ram_rd_data;
	logic                  ram_rd_en;
	logic                  ram_wr_en;
	logic [IDX_W-1:0]      ram_wr_addr;
	logic [COUNT_BITS-1:0] ram_wr_data;

	logic [COUNT_BITS-1:0] cur_count;
	logic                  wb_active;
	logic                  wb_expire;
	logic [BANK_SIZE-1:0]  wb_bit;

	logic                  res_fire;
	ctb_pkg::rsp_t         res;
	logic                  out_free;

	assign cmd_stall = (state_q != ST_IDLE) || hold_valid_q;
	assign cmd_fire  = cmd_valid && !cmd_stall;
	assign is_tick   = (cmd.kind == ctb_pkg::KIND_TICK);
	assign in_range  = cmd.timer_index < 8'(BANK_SIZE);
	assign idx       = cmd.timer_index[IDX_W-1:0];
	assign sel_bit   = BANK_SIZE'(1) << idx;
	assign op_fire   = cmd_fire && !is_tick && in_range;

	always_comb begin
		op_active  = active_q;
		op_expired = expired_q;
		op_write   = 1'b0;
		case (cmd.kind)
			ctb_pkg::KIND_LOAD: begin
				op_active  = active_q | sel_bit;
				op_expired = expired_q & ~sel_bit;
				op_write   = 1'b1;
			end
			ctb_pkg::KIND_START: begin
				op_active = active_q | sel_bit;
			end
			ctb_pkg::KIND_STOP: begin
				op_active = active_q & ~sel_bit;
			end
			ctb_pkg::KIND_SET: begin
				op_write = 1'b1;
			end
			ctb_pkg::KIND_CLEAR: begin
				op_expired = expired_q & ~sel_bit;
			end
			default: begin
			end
		endcase
	end

	assign cur_count = valid_q[wb_idx_s1] ? ram_rd_data : '0;
	assign wb_active = wb_valid_s1 && active_q[wb_idx_s1];
	assign wb_expire = cur_count <= COUNT_BITS'(1);
	assign wb_bit    = BANK_SIZE'(1) << wb_idx_s1;

	assign ram_rd_en = (state_q == ST_SWEEP);

	always_comb begin
		ram_wr_en   = 1'b0;
		ram_wr_addr = idx;
		ram_wr_data = COUNT_BITS'(cmd.load_value);
		if (wb_active) begin
			ram_wr_en   = 1'b1;
			ram_wr_addr = wb_idx_s1;
			ram_wr_data = wb_expire ? '0 : cur_count - COUNT_BITS'(1);
		end else if (op_fire && op_write) begin
			ram_wr_en = 1'b1;
		end
	end

	ctb_ram #(
		.WIDTH(COUNT_BITS),
		.DEPTH(BANK_SIZE)
	) u_count_ram (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(ram_wr_addr),
		.wr_data(ram_wr_data),
		.rd_en  (ram_rd_en),
		.rd_addr(sweep_q),
		.rd_data(ram_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sweep_q     <= '0;
			wb_valid_s1 <= 1'b0;
			wb_idx_s1   <= '0;
			tick_q      <= '0;
		end else begin
			wb_valid_s1 <= ram_rd_en;
			wb_idx_s1   <= sweep_q;
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_fire && is_tick) begin
						tick_q  <= tick_q + 32'd1;
						sweep_q <= '0;
						state_q <= ST_SWEEP;
					end
				end
				ST_SWEEP: begin
					if (sweep_q == IDX_W'(BANK_SIZE - 1)) begin
						state_q <= ST_DRAIN;
					end else begin
						sweep_q <= sweep_q + IDX_W'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= '0;
			expired_q <= '0;
			valid_q   <= '0;
		end else begin
			if (wb_active && wb_expire) begin
				active_q  <= active_q & ~wb_bit;
				expired_q <= expired_q | wb_bit;
			end else if (op_fire) begin
				active_q  <= op_active;
				expired_q <= op_expired;
			end
			if (ram_wr_en) begin
				valid_q <= valid_q | (BANK_SIZE'(1) << ram_wr_addr);
			end
		end
	end

	always_comb begin
		res_fire       = 1'b0;
		res.status     = 1'b0;
		res.is_active  = 1'b0;
		res.is_expired = 1'b0;
		res.now_time   = tick_q;
		if (state_q == ST_DRAIN) begin
			res_fire = 1'b1;
		end else if (cmd_fire && !is_tick) begin
			res_fire       = 1'b1;
			res.status     = !in_range;
			res.is_active  = in_range && op_active[idx];
			res.is_expired = in_range && op_expired[idx];
		end
	end

	assign out_free = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q  <= 1'b0;
			hold_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				rsp_valid_q  <= hold_valid_q || res_fire;
				hold_valid_q <= 1'b0;
			end else if (res_fire) begin
				hold_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			rsp_q <= hold_valid_q ? hold_q : res;
		end else if (res_fire) begin
			hold_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef ASSERT_OFF
	a_hold_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		hold_valid_q |-> rsp_valid_q)
		else $error("hold register full while output register is empty");

	a_tick_starts_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_fire && is_tick |=> state_q == ST_SWEEP && sweep_q == '0)
		else $error("tick beat did not start a sweep at timer zero");

	a_writeback_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		wb_valid_s1 |-> state_q == ST_SWEEP || state_q == ST_DRAIN)
		else $error("count write-back outside a sweep");

	a_drain_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DRAIN |=> state_q == ST_IDLE && (rsp_valid_q || hold_valid_q))
		else $error("sweep ended without a result");
`endif

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

	localparam int TIMER_N = ctb_pkg::BANK_SIZE_DEF;
	localparam int CNT_W = ctb_pkg::COUNT_BITS_DEF;
	localparam int SLOT_W = (TIMER_N > 1) ? $clog2(TIMER_N) : 1;
	localparam logic [2:0] KIND_SPARE = 3'd7;
	localparam int STUCK_LIMIT = 1000;
	localparam int DRAIN_CYCLES = 40;

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	ctb_pkg::cmd_t cmd;
	logic rsp_valid;
	logic rsp_stall;
	ctb_pkg::rsp_t rsp;

	logic [CNT_W-1:0] timer_count [TIMER_N];
	logic [TIMER_N-1:0] active_bits;
	logic [TIMER_N-1:0] expired_bits;
	logic [31:0] tick_count;

	ctb_pkg::rsp_t timer_report_q [$];

	bit idle_on;
	int unsigned fail_count;
	int unsigned sent_count;
	int unsigned tick_sent;
	int unsigned bad_index_sent;
	int unsigned reports_checked;
	int unsigned expired_seen;
	int unsigned stuck_cycles;

	countdown_timer_bank_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (!idle_on) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end
		if (r < 88) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(6, 40);
	endfunction

	function automatic ctb_pkg::rsp_t apply_timer_op(ctb_pkg::cmd_t c);
		ctb_pkg::rsp_t r;
		logic [SLOT_W-1:0] slot;
		r = '0;
		if (c.kind == ctb_pkg::KIND_TICK) begin
			tick_count = tick_count + 32'd1;
			for (int i = 0; i < TIMER_N; i++) begin
				if (active_bits[i]) begin
					if (timer_count[i] <= 1) begin
						timer_count[i] = '0;
						expired_bits[i] = 1'b1;
						active_bits[i] = 1'b0;
					end else begin
						timer_count[i] = timer_count[i] - 1'b1;
					end
				end
			end
			r.now_time = tick_count;
			return r;
		end
		if (c.timer_index >= TIMER_N) begin
			r.status = 1'b1;
			r.now_time = tick_count;
			return r;
		end
		slot = c.timer_index[SLOT_W-1:0];
		case (c.kind)
			ctb_pkg::KIND_LOAD: begin
				timer_count[slot] = c.load_value[CNT_W-1:0];
				expired_bits[slot] = 1'b0;
				active_bits[slot] = 1'b1;
			end
			ctb_pkg::KIND_START: begin
				active_bits[slot] = 1'b1;
			end
			ctb_pkg::KIND_STOP: begin
				active_bits[slot] = 1'b0;
			end
			ctb_pkg::KIND_SET: begin
				timer_count[slot] = c.load_value[CNT_W-1:0];
			end
			ctb_pkg::KIND_CLEAR: begin
				expired_bits[slot] = 1'b0;
			end
			default: begin
			end
		endcase
		r.is_active = active_bits[slot];
		r.is_expired = expired_bits[slot];
		r.now_time = tick_count;
		return r;
	endfunction

	task automatic send_timer_op(input logic [2:0] kind, input logic [7:0] idx,
			input logic [15:0] value);
		int unsigned gap;
		ctb_pkg::cmd_t c;
		gap = pick_gap();
		c.kind = kind;
		c.timer_index = idx;
		c.load_value = value;
		if (gap != 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		timer_report_q.push_back(apply_timer_op(c));
		sent_count++;
		if (kind == ctb_pkg::KIND_TICK) begin
			tick_sent++;
		end else if (idx >= TIMER_N) begin
			bad_index_sent++;
		end
	endtask

	initial begin
		rsp_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			int unsigned hold;
			int unsigned run;
			hold = pick_gap();
			run = $urandom_range(1, 6);
			repeat (run) @(posedge clk);
			if (hold != 0) begin
				rsp_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				rsp_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		ctb_pkg::rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (timer_report_q.size() == 0) begin
				$error("Response beat arrived with no command outstanding: %h", rsp);
				fail_count++;
			end else begin
				want = timer_report_q.pop_front();
				reports_checked++;
				if (want.is_expired) begin
					expired_seen++;
				end
				if (rsp.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp.status);
					fail_count++;
				end
				if (rsp.is_active !== want.is_active) begin
					$error("is_active: expected %0d, got %0d", want.is_active,
						rsp.is_active);
					fail_count++;
				end
				if (rsp.is_expired !== want.is_expired) begin
					$error("is_expired: expected %0d, got %0d", want.is_expired,
						rsp.is_expired);
					fail_count++;
				end
				if (rsp.now_time !== want.now_time) begin
					$error("now_time: expected %0d, got %0d", want.now_time, rsp.now_time);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)) begin
				stuck_cycles <= 0;
			end else if (stuck_cycles >= STUCK_LIMIT) begin
				$display("Watchdog: no beat moved for %0d cycles.", STUCK_LIMIT);
				$display("FAIL");
				$finish;
			end else begin
				stuck_cycles <= stuck_cycles + 1;
			end
		end
	end

	function automatic logic [7:0] rand_index();
		if ($urandom_range(0, 9) == 0) begin
			return 8'($urandom_range(TIMER_N, 255));
		end
		return 8'($urandom_range(0, TIMER_N - 1));
	endfunction

	function automatic logic [15:0] rand_count();
		if ($urandom_range(0, 9) < 7) begin
			return 16'($urandom_range(0, 6));
		end
		return 16'($urandom);
	endfunction

	task automatic test_reset_query();
		send_timer_op(ctb_pkg::KIND_QUERY, 8'd0, 16'd0);
		send_timer_op(ctb_pkg::KIND_QUERY, 8'(TIMER_N - 1), 16'hFFFF);
	endtask

	task automatic test_load_and_expire();
		send_timer_op(ctb_pkg::KIND_LOAD, 8'd3, 16'd2);
		send_timer_op(ctb_pkg::KIND_TICK, 8'd0, 16'd0);
		send_timer_op(ctb_pkg::KIND_QUERY, 8'd3, 16'd0);
		send_timer_op(ctb_pkg::KIND_TICK, 8'hFF, 16'hFFFF);
	endtask

	task automatic test_zero_count();
		send_timer_op(ctb_pkg::KIND_LOAD, 8'd4, 16'd0);
		send_timer_op(ctb_pkg::KIND_TICK, 8'd0, 16'd0);
		send_timer_op(ctb_pkg::KIND_SET, 8'd5, 16'd0);
		send_timer_op(ctb_pkg::KIND_START, 8'd5, 16'd0);
		send_timer_op(ctb_pkg::KIND_TICK, 8'd0, 16'd0);
	endtask

	// Start, stop and set leave the expired flag of timer 3 alone; clear drops it.
	task automatic test_flag_ops();
		send_timer_op(ctb_pkg::KIND_START, 8'd3, 16'd0);
		send_timer_op(ctb_pkg::KIND_STOP, 8'd3, 16'd0);
		send_timer_op(ctb_pkg::KIND_SET, 8'd3, 16'd7);
		send_timer_op(ctb_pkg::KIND_CLEAR, 8'd3, 16'd0);
	endtask

	task automatic test_bad_index();
		send_timer_op(ctb_pkg::KIND_LOAD, 8'(TIMER_N), 16'd5);
		send_timer_op(ctb_pkg::KIND_QUERY, 8'd255, 16'd0);
		send_timer_op(KIND_SPARE, 8'(TIMER_N - 1), 16'd0);
		send_timer_op(KIND_SPARE, 8'd200, 16'hFFFF);
	endtask

	task automatic test_field_extremes();
		send_timer_op(ctb_pkg::KIND_LOAD, 8'(TIMER_N - 1), 16'hFFFF);
		send_timer_op(ctb_pkg::KIND_SET, 8'd0, 16'hFFFF);
		send_timer_op(ctb_pkg::KIND_STOP, 8'(TIMER_N - 1), 16'd0);
	endtask

	task automatic test_random_traffic(input int unsigned count);
		int unsigned r;
		for (int unsigned n = 0; n < count; n++) begin
			r = $urandom_range(0, 99);
			if (r < 30) begin
				send_timer_op(ctb_pkg::KIND_TICK, 8'($urandom), 16'($urandom));
			end else if (r < 45) begin
				send_timer_op(ctb_pkg::KIND_LOAD, rand_index(), rand_count());
			end else if (r < 52) begin
				send_timer_op(ctb_pkg::KIND_START, rand_index(), 16'($urandom));
			end else if (r < 59) begin
				send_timer_op(ctb_pkg::KIND_STOP, rand_index(), 16'($urandom));
			end else if (r < 66) begin
				send_timer_op(ctb_pkg::KIND_SET, rand_index(), rand_count());
			end else if (r < 73) begin
				send_timer_op(ctb_pkg::KIND_CLEAR, rand_index(), 16'($urandom));
			end else if (r < 93) begin
				send_timer_op(ctb_pkg::KIND_QUERY, rand_index(), 16'($urandom));
			end else begin
				send_timer_op(KIND_SPARE, rand_index(), 16'($urandom));
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cmd_valid <= 1'b0;
		cmd <= '0;
		idle_on = 1'b1;
		for (int i = 0; i < TIMER_N; i++) begin
			timer_count[i] = '0;
		end
		active_bits = '0;
		expired_bits = '0;
		tick_count = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_query();
		test_load_and_expire();
		test_zero_count();
		test_flag_ops();
		test_bad_index();
		test_field_extremes();
		test_random_traffic(700);
		idle_on = 1'b0;
		test_random_traffic(300);
		idle_on = 1'b1;
		test_random_traffic(728);
		cmd_valid <= 1'b0;

		while (timer_report_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d commands: %0d ticks and %0d with an index past the bank.",
			sent_count, tick_sent, bad_index_sent);
		$display("Checked %0d responses, %0d of them reporting an expired timer.",
			reports_checked, expired_seen);
		if (fail_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
